[sv/masked_mean_pool_l2_normalize_core_assert.svh]
// Assertion macros used by the pooling core module.
`ifndef MASKED_MEAN_POOL_L2_NORMALIZE_CORE_ASSERT_SVH
`define MASKED_MEAN_POOL_L2_NORMALIZE_CORE_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define MMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the next cycle.
`define MMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mmp_pkg.sv]
package mmp_pkg;
  localparam int unsigned DimensionDefault = 64;
  localparam int unsigned MaxTokensDefault = 512;
  localparam int unsigned HidW  = 16;
  localparam int unsigned AccW  = 26;
  localparam int unsigned OutW  = 16;
  // Sum of squares of up to 1024 accumulators of 26 bits.
  localparam int unsigned SqW   = 2 * AccW;
  localparam int unsigned SumW  = SqW + 10;
  localparam int unsigned RootW = SumW / 2;
  localparam int unsigned QuoW  = 17;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic [4:0] {
    StAcc  = 5'b00001,
    StSum  = 5'b00010,
    StRoot = 5'b00100,
    StDiv  = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  // Saturating add of one element into an accumulator.
  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                     input logic signed [HidW-1:0] h);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + (AccW+1)'(h);
    if (s > (AccW+1)'(AccMax)) return AccMax;
    if (s < (AccW+1)'(AccMin)) return AccMin;
    return s[AccW-1:0];
  endfunction
endpackage

[sv/mmp_ram.sv]
module mmp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[sv/mmp_isqrt.sv]
// Bit-pair restoring square root, one result bit per cycle.
module mmp_isqrt import mmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  op_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);
  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [SumW-1:0]  rem_q, rem_d;
  logic [SumW-1:0]  op_q, op_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d, done_d, done_q;
  logic [SumW+1:0]  trial, remsh;

  always_comb begin
    rem_d  = rem_q;
    op_d   = op_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    remsh  = {rem_q, op_q[SumW-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      op_d   = op_i;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      run_d  = 1'b1;
    end else if (run_q) begin
      op_d = {op_q[SumW-3:0], 2'b00};
      if (remsh >= trial) begin
        rem_d  = SumW'(remsh - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = SumW'(remsh);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    op_q   <= op_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

[sv/mmp_div.sv]
// Restoring divider: quotient of (2*mag*2^15 + r) / (2*r), one bit per cycle.
module mmp_div import mmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AccW-1:0]  mag_i,
  input  logic [RootW-1:0] root_i,
  output logic             done_o,
  output logic [QuoW-1:0]  quo_o
);
  localparam int unsigned NumW = AccW + 17;
  localparam int unsigned DenW = RootW + 1;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DenW:0]   sh;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    sh     = {rem_q[DenW-1:0], num_q[NumW-1]};
    if (start_i) begin
      num_d = NumW'({mag_i, 16'b0}) + NumW'(root_i);
      den_d = {root_i, 1'b0};
      rem_d = '0;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Quotient never exceeds 32768 + 1 since |a| <= r; keep 17 bits.
  assign quo_o  = num_q[QuoW-1:0];
  assign done_o = done_q;
endmodule

[sv/masked_mean_pool_l2_normalize_core.sv]
// Channel   Direction  Ports                                           Handshake
// input     in         hidden_value_i, token_mask_i, last_element_i    start_i & !busy_o
// result    out        embed_value_o, is_last_o                        valid_o strobe
//
// Accumulation takes one beat per cycle while busy_o is low: the accumulator
// memory is read in the cycle of acceptance and written back the next, with
// forwarding when the same dimension is touched back to back (DIMENSION of one).
// A beat marked last starts a drain: its write-back finishes, the squares of
// all entries are summed, the square root is taken, and then each entry in
// turn is divided by the root, emitted and its entry cleared; busy stays high
// until the last entry has been cleared.
// Reset is asynchronous and active low; after it a clearing pass writes zeros
// over every entry, which holds busy high until that pass is done.
// The receiver cannot stall: each result is shown for one cycle only.
`include "masked_mean_pool_l2_normalize_core_assert.svh"
module masked_mean_pool_l2_normalize_core import mmp_pkg::*; #(
  parameter int unsigned DIMENSION  = DimensionDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [HidW-1:0] hidden_value_i,
  input  logic                   token_mask_i,
  input  logic                   last_element_i,
  output logic                   valid_o,
  output logic signed [OutW-1:0] embed_value_o,
  output logic                   is_last_o
);
  localparam int unsigned AW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

  state_e state_q, state_d;
  logic [AW-1:0] pos_q, pos_d, idx_q, idx_d;
  logic          clr_q, clr_d;
  logic          wb_q;
  logic [AW-1:0] wb_addr_q;
  logic          wb_mask_q;
  logic signed [HidW-1:0] wb_hv_q;
  logic          wb_last_q;
  logic          sq_v_q;
  logic          sq_last_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic [RootW-1:0] root_q;
  logic          rd_v_q;
  logic          rd_last_q;
  logic          sum_issue;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [AccW-1:0] wdata, rdata;
  logic signed [AccW-1:0] acc_cur, acc_new;
  logic signed [AccW-1:0] a_q;
  logic            sqrt_start, sqrt_done, div_start, div_done;
  logic [RootW-1:0] root_w;
  logic [QuoW-1:0] quo;
  logic            accept;
  logic signed [OutW-1:0] res_d;
  logic            valid_q, last_q;
  logic signed [OutW-1:0] res_q;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StAcc) || clr_q || (wb_q && wb_last_q);

  mmp_ram #(.Width(AccW), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Forward the previous write when the same entry is read back to back.
  logic fwd_q;
  logic [AccW-1:0] fwd_data_q;
  assign acc_cur = fwd_q ? $signed(fwd_data_q) : $signed(rdata);
  assign acc_new = wb_mask_q ? sat_add(acc_cur, wb_hv_q) : acc_cur;

  // Reads for the sum of squares are issued until the last entry has gone out.
  assign sum_issue = (state_q == StSum) && !rd_last_q && !sq_last_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    clr_d   = clr_q;
    sum_d   = sum_q;
    we      = 1'b0;
    waddr   = wb_addr_q;
    wdata   = acc_new;
    raddr   = pos_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    if (clr_q) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = '0;
      idx_d = idx_q + 1'b1;
      if (idx_q == AW'(DIMENSION - 1)) begin
        clr_d = 1'b0;
        idx_d = '0;
      end
    end else begin
      unique case (state_q)
        StAcc: begin
          if (wb_q) we = 1'b1;
          if (accept) begin
            pos_d = (pos_q == AW'(DIMENSION - 1)) ? '0 : pos_q + 1'b1;
          end
          if (wb_q && wb_last_q) begin
            state_d = StSum;
            idx_d   = '0;
            sum_d   = '0;
            pos_d   = '0;
          end
          raddr = pos_q;
        end
        StSum: begin
          raddr = idx_q;
          if (sq_v_q) sum_d = sum_q + SumW'($unsigned(SqW'(a_q) * SqW'(a_q)));
          if (sum_issue && idx_q != AW'(DIMENSION - 1)) idx_d = idx_q + 1'b1;
          if (sq_last_q) begin
            state_d    = StRoot;
            sqrt_start = 1'b1;
            idx_d      = '0;
          end
        end
        StRoot: begin
          raddr = '0;
          if (sqrt_done) begin
            state_d   = StDiv;
            div_start = 1'b1;
          end
        end
        StDiv: begin
          raddr = idx_q + 1'b1;
          if (div_done) state_d = StEmit;
        end
        StEmit: begin
          we    = 1'b1;
          waddr = idx_q;
          wdata = '0;
          raddr = idx_q + 1'b1;
          if (idx_q == AW'(DIMENSION - 1)) begin
            state_d = StAcc;
            idx_d   = '0;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StDiv;
            div_start = 1'b1;
          end
        end
        default: state_d = StAcc;
      endcase
    end
  end

  // Control state, with the flags of the sum of squares pipeline: read -> register -> multiply-add.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StAcc;
      pos_q     <= '0;
      idx_q     <= '0;
      clr_q     <= 1'b1;
      wb_q      <= 1'b0;
      wb_last_q <= 1'b0;
      valid_q   <= 1'b0;
      rd_v_q    <= 1'b0;
      sq_v_q    <= 1'b0;
      fwd_q     <= 1'b0;
      rd_last_q <= 1'b0;
      sq_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      idx_q     <= idx_d;
      clr_q     <= clr_d;
      wb_q      <= accept;
      wb_last_q <= accept && last_element_i;
      fwd_q     <= accept && wb_q && (wb_addr_q == pos_q);
      rd_v_q    <= sum_issue;
      rd_last_q <= sum_issue && (idx_q == AW'(DIMENSION - 1));
      sq_v_q    <= rd_v_q;
      sq_last_q <= rd_last_q;
      valid_q   <= (state_q == StEmit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wb_addr_q <= pos_q;
      wb_mask_q <= token_mask_i;
      wb_hv_q   <= hidden_value_i;
    end
    fwd_data_q <= acc_new;
    a_q        <= $signed(rdata);
    sum_q      <= sum_d;
    if (sqrt_done) root_q <= root_w;
    res_q      <= res_d;
    last_q     <= (idx_q == AW'(DIMENSION - 1));
  end

  mmp_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .op_i(sum_d),
    .done_o(sqrt_done), .root_o(root_w)
  );

  // The divider loads the entry read in the previous cycle; entry 0 is read
  // during the root phase, each later one during the division before it.
  logic signed [AccW-1:0] div_a_q;
  always_ff @(posedge clk_i) begin
    if (div_start) div_a_q <= $signed(rdata);
  end

  logic [AccW-1:0] dmag;
  logic [RootW-1:0] droot;
  assign dmag  = rdata[AccW-1] ? AccW'(-$signed(rdata)) : rdata;
  assign droot = sqrt_done ? root_w : root_q;

  mmp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .mag_i(dmag), .root_i(droot),
    .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    res_d = '0;
    if (root_q != '0) begin
      if (div_a_q[AccW-1]) begin
        res_d = (quo >= QuoW'(32768)) ? OutW'(16'sh8000) : OutW'(-$signed({1'b0, quo}));
      end else begin
        res_d = (quo > QuoW'(32767)) ? OutW'(16'sh7fff) : OutW'(quo);
      end
    end
  end

  assign valid_o       = valid_q;
  assign embed_value_o = res_q;
  assign is_last_o     = last_q && valid_q;

  `MMP_ASSERT_IMPL(a_no_accept_drain, clk_i, rst_ni, state_q != StAcc, busy_o, "accepted in drain")
  `MMP_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, state_q == StEmit, valid_o, "emit without result")
  `MMP_ASSERT_IMPL(a_last_valid, clk_i, rst_ni, is_last_o, valid_o, "is_last without valid")
  `MMP_ASSERT_IMPL(a_clr_busy, clk_i, rst_ni, clr_q, busy_o, "accept during clear")
endmodule

[test/tb_masked_mean_pool_l2_normalize_core.sv]
`timescale 1ns / 1ps

// Testbench for the masked mean pooling and L2 normalisation core.
// Every accepted element is fed into a local model of the accumulators. On a
// beat marked last, that model works out the whole unit-length embedding.
// The results are held in a queue, oldest first, and the checker process
// compares each strobed result against the head of that queue.
module tb_masked_mean_pool_l2_normalize_core;
  import mmp_pkg::*;

  localparam int unsigned Dim        = DimensionDefault;
  localparam int          OvfTokens  = 1;
  localparam longint      CycleLimit = 5000000;
  localparam int          RandItems  = 240;

  typedef struct packed {
    logic signed [OutW-1:0] value;
    logic                   last;
  } embed_beat_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic signed [HidW-1:0] hidden_value_i;
  logic                   token_mask_i;
  logic                   last_element_i;
  logic                   valid_o;
  logic signed [OutW-1:0] embed_value_o;
  logic                   is_last_o;

  masked_mean_pool_l2_normalize_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .hidden_value_i (hidden_value_i),
    .token_mask_i   (token_mask_i),
    .last_element_i (last_element_i),
    .valid_o        (valid_o),
    .embed_value_o  (embed_value_o),
    .is_last_o      (is_last_o)
  );

  // Local copy of the pooling state: one saturating sum per dimension and
  // the dimension that the next element belongs to.
  int          pool_acc [Dim];
  int unsigned pool_pos;
  embed_beat_t embed_q [$];
  int          error_count = 0;
  longint      cycle_count = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The run is cut short once the cycle counter passes CycleLimit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, embed_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Integer square root, rounded down, by the usual bit-pair method.
  function automatic longint unsigned isqrt(input longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Folds one accepted element into the model. On a last element it works
  // out the whole normalised vector, queues it and clears the model.
  task automatic predict_embedding(input logic signed [HidW-1:0] hv, input logic mask,
                                   input logic last);
    int              v;
    longint unsigned sumsq;
    longint unsigned root;
    longint unsigned mag;
    longint unsigned quo;
    embed_beat_t     beat;
    if (mask) begin
      v = pool_acc[pool_pos] + int'(hv);
      if (v > int'(AccMax)) v = int'(AccMax);
      if (v < int'(AccMin)) v = int'(AccMin);
      pool_acc[pool_pos] = v;
    end
    pool_pos = (pool_pos + 1) % Dim;
    if (last) begin
      sumsq = 0;
      for (int i = 0; i < Dim; i++) begin
        sumsq = sumsq + longint'(pool_acc[i]) * longint'(pool_acc[i]);
      end
      root = isqrt(sumsq);
      for (int i = 0; i < Dim; i++) begin
        // A zero vector, which includes a sequence with no masked token,
        // comes out as all zeros rather than dividing by zero.
        beat.value = '0;
        if (root != 0) begin
          mag = (pool_acc[i] < 0) ? longint'(-pool_acc[i]) : longint'(pool_acc[i]);
          quo = (2 * mag * 32768 + root) / (2 * root);
          // Only a positive magnitude of one full unit needs clamping.
          if (pool_acc[i] < 0) begin
            if (quo > 32768) quo = 32768;
            beat.value = OutW'(-longint'(quo));
          end else begin
            if (quo > 32767) quo = 32767;
            beat.value = OutW'(quo);
          end
        end
        beat.last = (i == Dim - 1);
        embed_q = {embed_q, beat};
        pool_acc[i] = 0;
      end
      pool_pos = 0;
    end
  endtask

  // Sends one beat, waits for it to be taken, then idles for the given
  // number of cycles. With no idling, start stays high for the next beat.
  task automatic send_element(input logic signed [HidW-1:0] hv, input logic mask,
                              input logic last, input int gap);
    start_i        <= 1'b1;
    hidden_value_i <= hv;
    token_mask_i   <= mask;
    last_element_i <= last;
    do @(posedge clk_i); while (busy_o);
    predict_embedding(hv, mask, last);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every queued result has come out.
  task automatic wait_drained;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (embed_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Each strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (embed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d last %0b",
                 $time, embed_value_o, is_last_o);
        error_count++;
      end else begin
        if (embed_value_o !== embed_q[0].value) begin
          $display("%0t: embed_value expected %0d actual %0d",
                   $time, embed_q[0].value, embed_value_o);
          error_count++;
        end
        if (is_last_o !== embed_q[0].last) begin
          $display("%0t: is_last expected %0b actual %0b",
                   $time, embed_q[0].last, is_last_o);
          error_count++;
        end
        void'(embed_q.pop_front());
      end
    end
  end

  // Corner cases: an empty mask, full-scale single elements, the last beat
  // masked off, and a short sequence that leaves the position mid-token.
  task automatic test_directed;
    send_element(16'sd1234, 1'b0, 1'b1, 0);
    send_element(16'sd32767, 1'b1, 1'b1, 3);
    send_element(-16'sd32768, 1'b1, 1'b1, 0);
    send_element(16'sd0, 1'b1, 1'b1, 1);
    send_element(-16'sd1, 1'b1, 1'b0, 0);
    send_element(16'sd1, 1'b1, 1'b0, 2);
    send_element(16'sd32767, 1'b0, 1'b1, 0);
    for (int i = 0; i < 10; i++) begin
      send_element((i % 2) ? -16'sd32768 : 16'sd32767, 1'b1, 1'b0, i % 3);
    end
    send_element(16'sh5555, 1'b1, 1'b0, 0);
    send_element(16'shAAAA, 1'b1, 1'b1, 0);
    wait_drained();
  endtask

  // Full-scale elements in two dimensions, one of each sign, with the other
  // dimensions kept small, sent back to back.
  task automatic test_full_scale;
    logic signed [HidW-1:0] hv;
    for (int t = 0; t < OvfTokens; t++) begin
      for (int d = 0; d < Dim; d++) begin
        if (d == 0) hv = 16'sd32767;
        else if (d == 1) hv = -16'sd32768;
        else hv = HidW'($urandom_range(0, 64)) - 16'sd32;
        send_element(hv, 1'b1, (t == OvfTokens - 1) && (d == Dim - 1), 0);
      end
    end
    wait_drained();
  endtask

  // Mostly whole sequences of one or two tokens with random masks; the rest
  // have a random length of 1 to 150, so the position can wrap mid-token.
  task automatic test_random;
    int                     sent;
    int                     len;
    logic                   mask;
    logic signed [HidW-1:0] hv;
    sent = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 9) < 8) len = Dim * $urandom_range(1, 2);
      else len = $urandom_range(1, 150);
      mask = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if (i % Dim == 0 && $urandom_range(0, 3) != 0) mask = $urandom_range(0, 1);
        if (len % Dim != 0) mask = $urandom_range(0, 1);
        case ($urandom_range(0, 7))
          0: hv = 16'sd32767;
          1: hv = -16'sd32768;
          default: hv = HidW'($urandom());
        endcase
        send_element(hv, mask, i == len - 1,
                     ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
      end
      sent = sent + len;
      if (sent > RandItems / 2 && sent - len <= RandItems / 2) wait_drained();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    hidden_value_i = '0;
    token_mask_i   = 1'b0;
    last_element_i = 1'b0;
    pool_pos       = 0;
    for (int i = 0; i < Dim; i++) pool_acc[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_scale();
    test_random();
    wait_drained();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/mmp_pkg.sv
sv/mmp_ram.sv
sv/mmp_isqrt.sv
sv/mmp_div.sv
sv/masked_mean_pool_l2_normalize_core.sv
test/tb_masked_mean_pool_l2_normalize_core.sv
